// File: hw/rtl/mlbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlbc_pkg: shared types and constants of the LED blink controller
// Per-LED entry layout, result layout, command codes and the control and
// status bundles passed between sequencer and datapath.
// ----------------------------------------------------------------------------
package mlbc_pkg;

	// stream widths (payload padded to whole bytes)
	localparam int IN_W  = 40;
	localparam int OUT_W = 8;

	// command codes
	localparam logic [2:0] FN_ON      = 3'd0;
	localparam logic [2:0] FN_OFF     = 3'd1;
	localparam logic [2:0] FN_BLINK   = 3'd2;
	localparam logic [2:0] FN_TICK    = 3'd3;
	localparam logic [2:0] FN_SERVICE = 3'd4;

	// configuration register indexes
	localparam logic CFG_ON_LEVEL    = 1'b0;
	localparam logic CFG_ENABLE_MASK = 1'b1;

	// toggle counts at or above this value never run down
	localparam logic [8:0]  FOREVER_COUNT = 9'd510;
	localparam logic [15:0] TIME_MAX      = 16'hFFFF;
	// results reported by one service pass at most
	localparam logic [3:0]  MAX_RESULTS   = 4'd8;
	// LEDs that can be enabled through the mask
	localparam int          MASK_BITS     = 8;

	// per-LED state held in the entry memory
	typedef struct packed {
		logic        blink;
		logic [8:0]  toggles;
		logic        lit;
		logic [15:0] elapsed;
		logic [15:0] half;
	} entry_t;

	// one result, without the last flag
	typedef struct packed {
		logic       blinking;
		logic       drive;
		logic       pin_level;
		logic [2:0] led_index;
	} result_t;

	// sequencer to datapath
	typedef struct packed {
		logic       capture;
		logic       rd;
		logic       exec;
		logic       flush;
		logic       skip;
		logic [2:0] op;
	} cmd_t;

	// datapath to sequencer
	typedef struct packed {
		logic emit;
		logic busy;
	} stat_t;

endpackage : mlbc_pkg
`default_nettype wire

// File: hw/rtl/multi_led_blink_controller_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_led_blink_controller_core: bank of LED drivers with blink sequencing
// On/off/blink commands per LED, a tick that advances every LED timer and a
// service pass that toggles the LEDs whose half period has run out.
//
//   Channel   Dir  Handshake                      Content
//   s_axis    in   s_axis_tvalid/s_axis_tready    one command
//   m_axis    out  m_axis_tvalid/m_axis_tready    one LED report, tlast ends it
//   cfg       in   cfg_we                         on_level, enable_mask
//
// On, off and blink pass through accept, entry read, update and flush.
// Tick and service accept, then give each LED entry a memory read step and
// an update step on the single-port entry memory, then flush.
// One command is in flight at a time; an update step with a new report, and
// the flush, wait while both the held report and the output register are full.
// Reset clears all LED state at once.
// ----------------------------------------------------------------------------
module multi_led_blink_controller_core import mlbc_pkg::*; #(
	parameter int LED_COUNT = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [7:0]       cfg_data,
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	// func[2:0], led[5:3], interval[21:6], blink_count[29:22], tick_step[37:30]
	input  wire logic [IN_W-1:0]  s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	// led_index[2:0], pin_level[3], drive[4], blinking[5]
	output logic [OUT_W-1:0]      m_axis_tdata,
	output logic                  m_axis_tlast
);

	localparam int AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

	cmd_t          cmd;
	stat_t         stat;
	logic [AW-1:0] idx;
	result_t       res;

	mlbc_ctrl #(
		.LED_COUNT(LED_COUNT),
		.AW       (AW)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.func    (s_axis_tdata[2:0]),
		.led     (s_axis_tdata[5:3]),
		.stat    (stat),
		.cmd     (cmd),
		.idx     (idx)
	);

	mlbc_dp #(
		.LED_COUNT(LED_COUNT),
		.AW       (AW)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.led        (s_axis_tdata[5:3]),
		.interval   (s_axis_tdata[21:6]),
		.blink_count(s_axis_tdata[29:22]),
		.tick_step  (s_axis_tdata[37:30]),
		.cmd        (cmd),
		.idx        (idx),
		.stat       (stat),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_data   (res),
		.out_last   (m_axis_tlast)
	);

	// pad the report to a whole byte
	assign m_axis_tdata = {2'b00, res};

endmodule : multi_led_blink_controller_core
`default_nettype wire

// File: hw/rtl/mlbc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlbc_ctrl: command sequencer
// Takes one transaction at a time, walks the entry memory (one entry for a
// command, every entry for tick and service) and flushes the held result.
// ----------------------------------------------------------------------------
module mlbc_ctrl import mlbc_pkg::*; #(
	parameter int LED_COUNT = 8,
	parameter int AW        = 3
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [2:0]    func,
	input  wire logic [2:0]    led,
	input  wire stat_t         stat,
	output cmd_t               cmd,
	output logic [AW-1:0]      idx
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EXEC,
		ST_FLUSH
	} state_t;

	localparam logic [AW-1:0] LAST_IDX = AW'(LED_COUNT - 1);

	state_t        state_q;
	logic [2:0]    func_q;
	logic          skip_q;
	logic [AW-1:0] idx_q;
	logic          led_ok;
	logic          is_sweep;
	logic          exec_go;
	logic          accept;

	assign led_ok   = int'(led) < LED_COUNT;
	assign is_sweep = func_q inside {FN_TICK, FN_SERVICE};
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	// an execute step waits only when it has a result and no room for it
	assign exec_go  = (state_q == ST_EXEC) && !(stat.emit && stat.busy);

	// command decode
	always_comb begin
		cmd         = '0;
		cmd.capture = accept;
		cmd.rd      = (state_q == ST_READ);
		cmd.exec    = exec_go;
		cmd.flush   = (state_q == ST_FLUSH) && !stat.busy;
		cmd.skip    = skip_q;
		cmd.op      = func_q;
	end

	assign idx = idx_q;

	// state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			func_q  <= FN_ON;
			skip_q  <= 1'b0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						func_q <= func;
						skip_q <= 1'b0;
						if (func inside {FN_ON, FN_OFF, FN_BLINK}) begin
							if (led_ok) begin
								idx_q   <= AW'(led);
								state_q <= ST_READ;
							end else begin
								skip_q  <= 1'b1;
								state_q <= ST_EXEC;
							end
						end else if (func inside {FN_TICK, FN_SERVICE}) begin
							idx_q   <= '0;
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (exec_go) begin
						if (is_sweep && idx_q != LAST_IDX) begin
							idx_q   <= idx_q + AW'(1);
							state_q <= ST_READ;
						end else begin
							state_q <= ST_FLUSH;
						end
					end
				end
				ST_FLUSH: begin
					if (!stat.busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule : mlbc_ctrl
`default_nettype wire

// File: hw/rtl/mlbc_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlbc_dp: LED state datapath
// Entry memory with valid bits, per-entry update logic, configuration
// registers, a held result for last marking and the output register.
// ----------------------------------------------------------------------------
module mlbc_dp import mlbc_pkg::*; #(
	parameter int LED_COUNT = 8,
	parameter int AW        = 3
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic          cfg_index,
	input  wire logic [7:0]    cfg_data,
	input  wire logic [2:0]    led,
	input  wire logic [15:0]   interval,
	input  wire logic [7:0]    blink_count,
	input  wire logic [7:0]    tick_step,
	input  wire cmd_t          cmd,
	input  wire logic [AW-1:0] idx,
	output stat_t              stat,
	output logic               out_valid,
	input  wire logic          out_ready,
	output result_t            out_data,
	output logic               out_last
);

	// configuration
	logic       on_level_q;
	logic [7:0] enable_mask_q;

	// captured payload
	logic [2:0]  led_q;
	logic [15:0] ivl_q;
	logic [7:0]  cnt_q;
	logic [7:0]  step_q;
	logic [3:0]  res_cnt_q;

	// entry memory
	entry_t                mem [LED_COUNT];
	logic [LED_COUNT-1:0]  vld_q;
	entry_t                rd_q;
	logic                  rd_vld_q;
	entry_t                cur;

	// update logic
	entry_t      nxt;
	result_t     res;
	logic        emit;
	logic        wr;
	logic [6:0]  idx_w;
	logic        en;
	logic [16:0] sum;

	// held result and output register
	logic    pend_q;
	result_t pend_data_q;
	logic    out_valid_q;
	result_t out_data_q;
	logic    out_last_q;
	logic    push;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_level_q    <= 1'b1;
			enable_mask_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ON_LEVEL:    on_level_q    <= cfg_data[0];
				CFG_ENABLE_MASK: enable_mask_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// payload capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			led_q  <= led;
			ivl_q  <= interval;
			cnt_q  <= blink_count;
			step_q <= tick_step;
		end
	end

	// results counted within one transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_cnt_q <= '0;
		end else if (cmd.capture) begin
			res_cnt_q <= '0;
		end else if (cmd.exec && emit && res_cnt_q != MAX_RESULTS) begin
			res_cnt_q <= res_cnt_q + 4'd1;
		end
	end

	// memory read and write
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_q <= mem[idx];
		end
		if (cmd.exec && wr) begin
			mem[idx] <= nxt;
		end
	end

	// valid bits: an unwritten entry reads as all zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (cmd.rd) begin
				rd_vld_q <= vld_q[idx];
			end
			if (cmd.exec && wr) begin
				vld_q[idx] <= 1'b1;
			end
		end
	end

	assign cur   = rd_vld_q ? rd_q : '0;
	assign idx_w = 7'(idx);
	assign en    = (idx_w < 7'(MASK_BITS)) && enable_mask_q[idx_w[2:0]];
	assign sum   = {1'b0, cur.elapsed} + {9'd0, step_q};

	// per-entry update and result
	always_comb begin
		nxt           = cur;
		res           = '0;
		res.led_index = idx_w[2:0];
		emit          = 1'b0;
		wr            = 1'b0;
		if (cmd.skip) begin
			res.led_index = led_q;
			emit          = 1'b1;
		end else begin
			case (cmd.op)
				FN_ON, FN_OFF: begin
					emit = 1'b1;
					if (en) begin
						wr            = 1'b1;
						nxt.blink     = 1'b0;
						nxt.lit       = (cmd.op == FN_ON);
						res.pin_level = nxt.lit ? on_level_q : ~on_level_q;
						res.drive     = 1'b1;
					end else begin
						res.blinking = cur.blink;
					end
				end
				FN_BLINK: begin
					emit         = 1'b1;
					wr           = 1'b1;
					nxt.blink    = 1'b1;
					nxt.half     = ivl_q;
					nxt.toggles  = {cnt_q, 1'b0};
					nxt.elapsed  = '0;
					res.blinking = 1'b1;
				end
				FN_TICK: begin
					wr          = 1'b1;
					nxt.elapsed = sum[16] ? TIME_MAX : sum[15:0];
				end
				FN_SERVICE: begin
					if (en && cur.blink && cur.elapsed >= cur.half) begin
						wr          = 1'b1;
						nxt.elapsed = '0;
						if (cur.toggles != '0) begin
							if (cur.toggles < FOREVER_COUNT) begin
								nxt.toggles = cur.toggles - 9'd1;
							end
							nxt.lit       = ~cur.lit;
							emit          = (res_cnt_q != MAX_RESULTS);
							res.pin_level = nxt.lit ? on_level_q : ~on_level_q;
							res.drive     = 1'b1;
							res.blinking  = 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// a new result or the flush moves the held one to the output register
	assign stat.emit = emit;
	assign stat.busy = pend_q && out_valid_q && !out_ready;
	assign push      = pend_q && ((cmd.exec && emit) || cmd.flush);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			if (cmd.exec && emit) begin
				pend_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_q <= 1'b0;
			end
			if (push) begin
				out_valid_q <= 1'b1;
				out_last_q  <= cmd.flush;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && emit) begin
			pend_data_q <= res;
		end
		if (push) begin
			out_data_q <= pend_data_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;

endmodule : mlbc_dp
`default_nettype wire

// File: tb/mlbc_report_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlbc_report_checker: scoreboard for the LED blink controller
// Watches the register port and both streams. Keeps its own copy of the
// per-LED blink state, predicts the LED reports of every accepted command and
// compares each accepted report, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module mlbc_report_checker import mlbc_pkg::*; #(
	parameter int LEDS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [7:0]       cfg_data,
	input  logic             s_axis_tvalid,
	input  logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,
	input  logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	input  logic [OUT_W-1:0] m_axis_tdata,
	input  logic             m_axis_tlast,
	output int               fail_count,
	output int               reports_due,
	output int               cmd_count,
	output int               report_count
);

	// command word, lowest field last
	typedef struct packed {
		logic [1:0]  pad;
		logic [7:0]  tick_step;
		logic [7:0]  blink_count;
		logic [15:0] interval;
		logic [2:0]  led;
		logic [2:0]  func;
	} led_cmd_t;

	typedef struct packed {
		result_t rep;
		logic    last;
	} led_report_t;

	entry_t      led_bank [LEDS];
	logic        lit_level;
	logic [7:0]  enabled_leds;
	led_report_t pending_reports [$];

	// pin level for a lit or dark LED under the current polarity
	function automatic logic pin_for(input logic lit);
		return lit ? lit_level : ~lit_level;
	endfunction

	function automatic void log_error(input string what);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t ns: %s", $realtime, what);
	endfunction

	// update the LED bank for one command and queue the reports it causes
	task automatic apply_command(input logic [IN_W-1:0] word);
		led_cmd_t    c;
		led_report_t r;
		logic [16:0] sum;
		int          n;
		c = led_cmd_t'(word);
		r = '0;
		n = 0;
		case (c.func)
			FN_ON, FN_OFF, FN_BLINK: begin
				r.rep.led_index = c.led;
				r.last          = 1'b1;
				if (c.func == FN_BLINK) begin
					// blink always takes effect, lit bit kept
					led_bank[c.led].blink   = 1'b1;
					led_bank[c.led].half    = c.interval;
					led_bank[c.led].toggles = {c.blink_count, 1'b0};
					led_bank[c.led].elapsed = '0;
					r.rep.blinking          = 1'b1;
				end else if (enabled_leds[c.led]) begin
					led_bank[c.led].blink = 1'b0;
					led_bank[c.led].lit   = (c.func == FN_ON);
					r.rep.pin_level       = pin_for(c.func == FN_ON);
					r.rep.drive           = 1'b1;
				end else begin
					// disabled LED: ignored, report the unchanged flag
					r.rep.blinking = led_bank[c.led].blink;
				end
				pending_reports.push_back(r);
			end
			FN_TICK: begin
				for (int i = 0; i < LEDS; i++) begin
					sum = {1'b0, led_bank[i].elapsed} + {9'd0, c.tick_step};
					led_bank[i].elapsed = sum[16] ? TIME_MAX : sum[15:0];
				end
			end
			FN_SERVICE: begin
				for (int i = 0; i < LEDS; i++) begin
					if (i < MASK_BITS && enabled_leds[i] && led_bank[i].blink &&
							led_bank[i].elapsed >= led_bank[i].half) begin
						led_bank[i].elapsed = '0;
						// exhausted count: time cleared, nothing driven
						if (led_bank[i].toggles != '0) begin
							if (led_bank[i].toggles < FOREVER_COUNT)
								led_bank[i].toggles--;
							led_bank[i].lit = ~led_bank[i].lit;
							if (n < MAX_RESULTS) begin
								r.rep.led_index = i[2:0];
								r.rep.pin_level = pin_for(led_bank[i].lit);
								r.rep.drive     = 1'b1;
								r.rep.blinking  = 1'b1;
								r.last          = 1'b0;
								pending_reports.push_back(r);
								n++;
							end
						end
					end
				end
				if (n > 0)
					pending_reports[pending_reports.size() - 1].last = 1'b1;
			end
			default: ;  // unused codes change nothing
		endcase
	endtask

	// sample both streams and the register port at each rising edge
	always @(posedge clk or negedge arst_n) begin
		led_report_t want;
		result_t     got;
		if (!arst_n) begin
			foreach (led_bank[i])
				led_bank[i] = '0;
			lit_level    = 1'b1;
			enabled_leds = '0;
			pending_reports.delete();
			fail_count   = 0;
			cmd_count    = 0;
			report_count = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = result_t'(m_axis_tdata[5:0]);
				report_count++;
				if (pending_reports.size() == 0) begin
					log_error($sformatf("unexpected report: led %0d lvl %0b drv %0b blink %0b last %0b",
						got.led_index, got.pin_level, got.drive, got.blinking, m_axis_tlast));
				end else begin
					want = pending_reports.pop_front();
					if (got.led_index !== want.rep.led_index ||
							got.pin_level !== want.rep.pin_level ||
							got.drive !== want.rep.drive ||
							got.blinking !== want.rep.blinking ||
							m_axis_tlast !== want.last)
						log_error($sformatf({"report mismatch: expected led %0d lvl %0b drv %0b ",
							"blink %0b last %0b, got led %0d lvl %0b drv %0b blink %0b last %0b"},
							want.rep.led_index, want.rep.pin_level, want.rep.drive,
							want.rep.blinking, want.last, got.led_index, got.pin_level,
							got.drive, got.blinking, m_axis_tlast));
				end
			end
			if (cfg_we) begin
				if (cfg_index == CFG_ON_LEVEL)
					lit_level = cfg_data[0];
				else if (cfg_index == CFG_ENABLE_MASK)
					enabled_leds = cfg_data;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				cmd_count++;
				apply_command(s_axis_tdata);
			end
		end
		reports_due = pending_reports.size();
	end

endmodule : mlbc_report_checker

// File: tb/tb_multi_led_blink_controller_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_led_blink_controller_core: stimulus and verdict for the LED core
// Directed commands first, then random command mixes under several polarity
// and enable settings, a timer saturation stretch, random idling on both
// streams and one long output stall. Checking is done by the scoreboard.
// ----------------------------------------------------------------------------
module tb_multi_led_blink_controller_core;
	import mlbc_pkg::*;

	localparam int          DRAIN_CYCLES = 40;   // a full tick or service sweep and margin
	localparam int          HOLD_CYCLES  = 300;  // long output stall
	localparam int unsigned TIMEOUT_NS   = 8_000_000;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic             cfg_index;
	logic [7:0]       cfg_data;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata;
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;
	logic             m_axis_tlast;

	int   fail_count;
	int   reports_due;
	int   cmd_count;
	int   report_count;
	int   settings_used;
	logic no_gaps;
	logic hold_req;

	multi_led_blink_controller_core #(
		.LED_COUNT(8)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	mlbc_report_checker #(
		.LEDS(8)
	) i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.fail_count   (fail_count),
		.reports_due  (reports_due),
		.cmd_count    (cmd_count),
		.report_count (report_count)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	initial begin
		#(TIMEOUT_NS);
		$display("FAIL multi_led_blink_controller_core");
		$finish;
	end

	function automatic logic [IN_W-1:0] make_cmd(input logic [2:0] fn, input logic [2:0] led,
			input logic [15:0] ivl, input logic [7:0] cnt, input logic [7:0] step);
		return {2'b00, step, cnt, ivl, led, fn};
	endfunction

	// command mix weighted toward blink, tick and service sequences
	function automatic logic [IN_W-1:0] random_cmd();
		int          pick;
		logic [2:0]  fn;
		logic [15:0] ivl;
		logic [7:0]  cnt;
		pick = $urandom_range(0, 99);
		if (pick < 6)       fn = FN_ON;
		else if (pick < 12) fn = FN_OFF;
		else if (pick < 26) fn = FN_BLINK;
		else if (pick < 58) fn = FN_TICK;
		else if (pick < 94) fn = FN_SERVICE;
		else                fn = 3'($urandom_range(5, 7));
		pick = $urandom_range(0, 99);
		if (pick < 65)      ivl = 16'($urandom_range(0, 255));
		else if (pick < 85) ivl = 16'($urandom_range(256, 4095));
		else                ivl = 16'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 45)      cnt = 8'($urandom_range(0, 3));
		else if (pick < 65) cnt = 8'hFF;
		else                cnt = 8'($urandom);
		return make_cmd(fn, 3'($urandom), ivl, cnt, 8'($urandom));
	endfunction

	function automatic int sender_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (no_gaps || pick < 45) return 0;
		if (pick < 92)            return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// offer one command and hold it until it is accepted
	task automatic send_cmd(input logic [IN_W-1:0] word);
		int gap;
		gap = sender_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = word;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// stop offering, wait for every report, then let a silent sweep finish
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (reports_due != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] value);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	task automatic set_regs(input logic level, input logic [7:0] mask);
		settle();
		write_reg(CFG_ON_LEVEL, {7'd0, level});
		write_reg(CFG_ENABLE_MASK, mask);
		settings_used++;
	endtask

	task automatic run_random(input int count);
		for (int k = 0; k < count; k++) begin
			no_gaps = (k % 50) < 10;
			send_cmd(random_cmd());
		end
		no_gaps = 1'b0;
	endtask

	// output side: random stalls, steady stretches, one long hold on request
	initial begin : report_sink
		int stall_left;
		int steady_left;
		stall_left    = 0;
		steady_left   = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req      = 1'b0;
				m_axis_tready = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else if (stall_left > 0) begin
				m_axis_tready = 1'b0;
				stall_left--;
			end else begin
				m_axis_tready = 1'b1;
				if (steady_left > 0)
					steady_left--;
				else if ($urandom_range(0, 99) < 4)
					steady_left = $urandom_range(20, 80);
				else if ($urandom_range(0, 99) < 25)
					stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) :
						$urandom_range(1, 3);
			end
		end
	end

	initial begin : stimulus
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_ON_LEVEL;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		no_gaps       = 1'b0;
		hold_req      = 1'b0;
		settings_used = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// directed: LED 7 disabled, active-high pins
		set_regs(1'b1, 8'h7F);
		send_cmd(make_cmd(FN_ON, 3'd0, 16'd0, 8'd0, 8'd0));
		send_cmd(make_cmd(FN_OFF, 3'd0, 16'd0, 8'd0, 8'd0));
		send_cmd(make_cmd(FN_ON, 3'd7, 16'hFFFF, 8'hFF, 8'hFF));     // disabled LED ignored
		send_cmd(make_cmd(FN_BLINK, 3'd7, 16'd0, 8'd0, 8'd0));       // blink on a disabled LED
		send_cmd(make_cmd(FN_OFF, 3'd7, 16'd0, 8'd0, 8'd0));         // keeps the blink flag
		send_cmd(make_cmd(FN_BLINK, 3'd0, 16'd0, 8'd1, 8'd0));
		send_cmd(make_cmd(FN_BLINK, 3'd1, 16'hFFFF, 8'hFF, 8'd0));   // endless blink
		send_cmd(make_cmd(FN_BLINK, 3'd2, 16'd5, 8'd0, 8'd0));       // zero count
		send_cmd(make_cmd(FN_BLINK, 3'd3, 16'd3, 8'd2, 8'd0));
		send_cmd(make_cmd(FN_SERVICE, 3'd0, 16'd0, 8'd0, 8'd0));
		send_cmd(make_cmd(FN_TICK, 3'd0, 16'd0, 8'd0, 8'd0));
		send_cmd(make_cmd(FN_TICK, 3'd0, 16'd0, 8'd0, 8'hFF));
		send_cmd(make_cmd(FN_SERVICE, 3'd0, 16'd0, 8'd0, 8'd0));
		send_cmd(make_cmd(FN_SERVICE, 3'd0, 16'd0, 8'd0, 8'd0));     // LED 0 run out
		send_cmd(make_cmd(3'd5, 3'($urandom), 16'($urandom), 8'($urandom), 8'($urandom)));
		send_cmd(make_cmd(3'd6, 3'($urandom), 16'($urandom), 8'($urandom), 8'($urandom)));
		send_cmd(make_cmd(3'd7, 3'($urandom), 16'($urandom), 8'($urandom), 8'($urandom)));
		send_cmd(make_cmd(FN_TICK, 3'd0, 16'd0, 8'd0, 8'hFF));
		send_cmd(make_cmd(FN_SERVICE, 3'd0, 16'd0, 8'd0, 8'd0));
		send_cmd(make_cmd(FN_ON, 3'd3, 16'd0, 8'd0, 8'd0));          // stops blinking
		send_cmd(make_cmd(FN_BLINK, 3'd4, 16'd0, 8'hFF, 8'd0));
		send_cmd(make_cmd(FN_SERVICE, 3'd0, 16'd0, 8'd0, 8'd0));

		// all LEDs enabled; a burst against a long output stall first
		set_regs(1'b1, 8'hFF);
		hold_req = 1'b1;
		no_gaps  = 1'b1;
		for (int k = 0; k < 24; k++)
			send_cmd((k % 3 == 0) ? make_cmd(FN_SERVICE, 3'd0, 16'd0, 8'd0, 8'd0) :
				random_cmd());
		no_gaps = 1'b0;
		run_random(30);

		set_regs(1'b0, 8'hFF);
		run_random(30);

		set_regs(1'b1, 8'($urandom));
		run_random(25);

		set_regs(1'b0, 8'h00);
		run_random(10);

		// timer saturation: only a saturated counter reaches the top interval
		set_regs(1'b1, 8'hFF);
		send_cmd(make_cmd(FN_BLINK, 3'd0, 16'hFFFF, 8'hFF, 8'd0));
		send_cmd(make_cmd(FN_BLINK, 3'd1, 16'hFFFF, 8'd1, 8'd0));
		for (int k = 0; k < 265; k++)
			send_cmd(make_cmd(FN_TICK, 3'($urandom), 16'($urandom), 8'($urandom),
				8'($urandom_range(250, 255))));
		send_cmd(make_cmd(FN_SERVICE, 3'd0, 16'd0, 8'd0, 8'd0));
		send_cmd(make_cmd(FN_TICK, 3'd0, 16'd0, 8'd0, 8'hFF));
		send_cmd(make_cmd(FN_SERVICE, 3'd0, 16'd0, 8'd0, 8'd0));
		run_random(20);

		settle();
		$display("Run covered %0d commands and %0d LED reports over %0d register settings,",
			cmd_count, report_count, settings_used);
		$display("including disabled LEDs, run-out and endless blinks, timer saturation and a long stall.");
		if (fail_count == 0 && reports_due == 0) begin
			$display("PASS multi_led_blink_controller_core");
		end else begin
			$display("FAIL multi_led_blink_controller_core");
		end
		$finish;
	end

endmodule : tb_multi_led_blink_controller_core
